// ===== rtl/photo_ycc_band_decoder_assert.svh =====
// Assertion macros used by the band decoder RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef PHOTO_YCC_BAND_DECODER_ASSERT_SVH
`define PHOTO_YCC_BAND_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PYCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("band decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PYCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("band decoder assertion failed");

`endif

// ===== rtl/pycc_pkg.sv =====
// Shared types, constants and helpers of the YCC band decoder.
// No dependencies; imported by pycc_convert, photo_ycc_band_decoder and tb.
package pycc_pkg;

	localparam int MAX_WIDTH = 768;
	localparam int MEM_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int LANES     = 5;
	localparam int LANE_W    = $clog2(LANES);
	localparam int SUM_W     = 28;

	// Byte lanes of one line store entry.
	localparam logic [LANE_W-1:0] LANE_Y1_EVEN = 3'd0;
	localparam logic [LANE_W-1:0] LANE_Y1_ODD  = 3'd1;
	localparam logic [LANE_W-1:0] LANE_Y2_EVEN = 3'd2;
	localparam logic [LANE_W-1:0] LANE_Y2_ODD  = 3'd3;
	localparam logic [LANE_W-1:0] LANE_CB      = 3'd4;

	localparam logic signed [18:0] K_Y    = 19'sd92241;
	localparam logic signed [18:0] K_RCR  = 19'sd86706;
	localparam logic signed [18:0] K_GCB  = -19'sd25914;
	localparam logic signed [18:0] K_GCR  = -19'sd44166;
	localparam logic signed [18:0] K_BCB  = 19'sd133434;
	localparam logic signed [8:0]  CB_OFS = 9'sd156;
	localparam logic signed [8:0]  CR_OFS = 9'sd137;

	localparam logic [1:0] MODE_192 = 2'd0;
	localparam logic [1:0] MODE_384 = 2'd1;
	localparam logic [1:0] MODE_768 = 2'd2;

	typedef enum logic [1:0] {
		PHASE_LUMA_ONE,
		PHASE_LUMA_TWO,
		PHASE_CHROMA
	} phase_t;

	// One pixel handed from the line store sequencer to the converter.
	typedef struct packed {
		logic       valid;
		logic [7:0] y;
		logic [7:0] cb;
		logic [7:0] cr;
		logic [8:0] row;
		logic [9:0] column;
		logic       last;
	} pix_req_t;

	// Line width for a mode; the unused code saturates to the widest size.
	function automatic logic [9:0] line_width(input logic [1:0] mode);
		case (mode)
			MODE_192: line_width = 10'd192;
			MODE_384: line_width = 10'd384;
			MODE_768: line_width = 10'd768;
			default:  line_width = 10'd768;
		endcase
	endfunction

	// Bands per image: width / 3.
	function automatic logic [8:0] band_count(input logic [1:0] mode);
		case (mode)
			MODE_192: band_count = 9'd64;
			MODE_384: band_count = 9'd128;
			MODE_768: band_count = 9'd256;
			default:  band_count = 9'd256;
		endcase
	endfunction

endpackage

// ===== rtl/pycc_convert.sv =====
// YCC to RGB conversion pipeline: difference, product and clamp stages.
// Depends on pycc_pkg. The last stage is the output register.
module pycc_convert import pycc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pix_req_t   req,
	input  logic       result_stall,
	output logic       adv,
	output logic       result_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [8:0] row,
	output logic [9:0] column,
	output logic       last
);

	logic              valid_s2, valid_s3, valid_s4;
	logic [7:0]        y_s2;
	logic signed [8:0] dcb_s2, dcr_s2;
	logic [8:0]        row_s2, row_s3;
	logic [9:0]        col_s2, col_s3;
	logic              last_s2, last_s3;
	logic signed [SUM_W-1:0] ly_s3, rcr_s3, gcb_s3, gcr_s3, bcb_s3;
	logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

	function automatic logic [7:0] clamp(input logic signed [SUM_W-1:0] s);
		if (s[SUM_W-1])
			clamp = 8'd0;
		else if (|s[SUM_W-2:24])
			clamp = 8'hFF;
		else
			clamp = s[23:16];
	endfunction

	// The whole pipeline holds while a finished word waits at the output.
	assign adv = !(valid_s4 && result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= req.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Both factors are widened to the sum width so no product is cut short.
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2    <= req.y;
			dcb_s2  <= $signed({1'b0, req.cb}) - CB_OFS;
			dcr_s2  <= $signed({1'b0, req.cr}) - CR_OFS;
			row_s2  <= req.row;
			col_s2  <= req.column;
			last_s2 <= req.last;

			ly_s3   <= SUM_W'(K_Y) * SUM_W'($signed({1'b0, y_s2}));
			rcr_s3  <= SUM_W'(K_RCR) * SUM_W'(dcr_s2);
			gcb_s3  <= SUM_W'(K_GCB) * SUM_W'(dcb_s2);
			gcr_s3  <= SUM_W'(K_GCR) * SUM_W'(dcr_s2);
			bcb_s3  <= SUM_W'(K_BCB) * SUM_W'(dcb_s2);
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;

			red     <= clamp(sum_r);
			green   <= clamp(sum_g);
			blue    <= clamp(sum_b);
			row     <= row_s3;
			column  <= col_s3;
			last    <= last_s3;
		end
	end

	always_comb begin
		sum_r = ly_s3 + rcr_s3;
		sum_g = ly_s3 + gcb_s3 + gcr_s3;
		sum_b = ly_s3 + bcb_s3;
	end

	assign result_valid = valid_s4;

endmodule

// ===== rtl/photo_ycc_band_decoder.sv =====
// Top level of the 4:2:0 YCC band decoder: counters, line store, pixel sequencer.
// Depends on pycc_pkg, pycc_convert and photo_ycc_band_decoder_assert.svh.
//
// Usage: bytes enter on data_byte with data_valid/data_stall; pixels leave on
// red/green/blue/row/column/last with result_valid/result_stall. A word moves
// when its valid is high and its stall is low. A band is luma row one, luma
// row two, then W/2 Cb bytes and W/2 Cr bytes. Luma and Cb bytes are written
// into one 384-entry line store (five byte lanes per entry) and are taken one
// per cycle. A Cr byte reads its entry once and then yields four pixels, one
// per cycle through the conversion pipeline while it is not held; the next
// Cr byte waits until the sequencer is free or being freed. The first
// pixel of a Cr byte is valid after the sequencer register and the pipeline's
// difference, product and output registers. While a finished pixel waits
// under result_stall the conversion pipeline holds; luma and Cb bytes are
// still taken, Cr bytes wait on a busy sequencer. Reset clears the counters
// and the mode (192x128); the line store has no reset and needs no clearing.
// Writing resolution_mode over the APB port restarts at band zero, row one.
module photo_ycc_band_decoder import pycc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [8:0]  row,
	output logic [9:0]  column,
	output logic        last
);

	`include "photo_ycc_band_decoder_assert.svh"

	logic [1:0]  mode_q;
	phase_t      phase_q;
	logic [9:0]  col_q;
	logic [7:0]  band_q;

	logic [9:0]  width, half, col_next;
	logic [8:0]  bands;
	logic        is_cr, accept, cr_accept, cfg_wr, adv, seq_done;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [LANE_W-1:0] wr_lane;

	logic [LANES-1:0][7:0] line_mem [MEM_DEPTH];
	logic [LANES-1:0][7:0] rd_s1;

	logic        hold_s1;
	logic [1:0]  px_s1;
	logic [7:0]  cr_s1;
	logic [8:0]  row_s1;
	logic [9:0]  col_s1;
	logic        end_s1;
	pix_req_t    req;

	assign pready = 1'b1;
	assign prdata = {30'd0, mode_q};
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	always_comb begin
		width    = line_width(mode_q);
		bands    = band_count(mode_q);
		half     = width >> 1;
		col_next = col_q + 10'd1;
		is_cr    = (phase_q == PHASE_CHROMA) && (col_q >= half);
		seq_done = adv && (px_s1 == 2'd3);
	end

	// A Cr byte needs the sequencer free, or freeing in this cycle.
	assign data_stall = is_cr && hold_s1 && !seq_done;
	assign accept     = data_valid && !data_stall;
	assign cr_accept  = accept && is_cr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_192;
			phase_q <= PHASE_LUMA_ONE;
			col_q   <= 10'd0;
			band_q  <= 8'd0;
		end else if (cfg_wr) begin
			mode_q  <= pwdata[1:0];
			phase_q <= PHASE_LUMA_ONE;
			col_q   <= 10'd0;
			band_q  <= 8'd0;
		end else if (accept) begin
			if (col_next == width) begin
				col_q <= 10'd0;
				case (phase_q)
					PHASE_LUMA_ONE: phase_q <= PHASE_LUMA_TWO;
					PHASE_LUMA_TWO: phase_q <= PHASE_CHROMA;
					default: begin
						phase_q <= PHASE_LUMA_ONE;
						if ({1'b0, band_q} + 9'd1 >= bands)
							band_q <= 8'd0;
						else
							band_q <= band_q + 8'd1;
					end
				endcase
			end else begin
				col_q <= col_next;
			end
		end
	end

	// Luma bytes pair up per entry by column; Cb byte k sits beside luma pair k.
	always_comb begin
		rd_addr = ADDR_W'(col_q - half);
		if (phase_q == PHASE_CHROMA) begin
			wr_addr = col_q[ADDR_W-1:0];
			wr_lane = LANE_CB;
		end else begin
			wr_addr = col_q[ADDR_W:1];
			if (phase_q == PHASE_LUMA_TWO)
				wr_lane = col_q[0] ? LANE_Y2_ODD : LANE_Y2_EVEN;
			else
				wr_lane = col_q[0] ? LANE_Y1_ODD : LANE_Y1_EVEN;
		end
	end

	// Every entry a Cr byte reads was written at least half a row earlier,
	// so a read never meets a write to the same entry.
	always_ff @(posedge clk) begin
		if (accept && !is_cr)
			line_mem[wr_addr][wr_lane] <= data_byte;
		if (cr_accept)
			rd_s1 <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_s1 <= 1'b0;
			px_s1   <= 2'd0;
		end else if (cr_accept) begin
			hold_s1 <= 1'b1;
			px_s1   <= 2'd0;
		end else if (adv && hold_s1) begin
			if (px_s1 == 2'd3)
				hold_s1 <= 1'b0;
			px_s1 <= px_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cr_accept) begin
			cr_s1  <= data_byte;
			row_s1 <= {band_q, 1'b0};
			col_s1 <= {rd_addr, 1'b0};
			end_s1 <= (col_next == width) && ({1'b0, band_q} + 9'd1 >= bands);
		end
	end

	always_comb begin
		req.valid  = hold_s1;
		req.y      = rd_s1[LANE_W'(px_s1)];
		req.cb     = rd_s1[LANE_CB];
		req.cr     = cr_s1;
		req.row    = row_s1 + {8'd0, px_s1[1]};
		req.column = col_s1 + {9'd0, px_s1[0]};
		req.last   = end_s1 && (px_s1 == 2'd3);
	end

	pycc_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.result_stall (result_stall),
		.adv          (adv),
		.result_valid (result_valid),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.row          (row),
		.column       (column),
		.last         (last)
	);

	`PYCC_ASSERT_NEXT(a_cr_starts_seq, cr_accept, hold_s1 && (px_s1 == 2'd0))
	`PYCC_ASSERT_NEXT(a_seq_steps, hold_s1 && adv && (px_s1 != 2'd3) && !cr_accept,
		hold_s1 && (px_s1 == $past(px_s1) + 2'd1))
	`PYCC_ASSERT_NOW(a_stall_only_cr, data_stall,
		(phase_q == PHASE_CHROMA) && (col_q >= half) && hold_s1)
	`PYCC_ASSERT_NOW(a_last_corner, result_valid && last, row[0] && column[0])

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for photo_ycc_band_decoder: a byte-level band decoder model,
// byte and pixel handshakes with random gaps and stalls, and APB mode writes.
// Depends on pycc_pkg and the decoder RTL only.
module tb import pycc_pkg::*; ();

	localparam longint COEF_Y    = 92241;
	localparam longint COEF_R_CR = 86706;
	localparam longint COEF_G_CB = -25914;
	localparam longint COEF_G_CR = -44166;
	localparam longint COEF_B_CB = 133434;
	localparam longint CB_CENTER = 156;
	localparam longint CR_CENTER = 137;

	localparam logic [2:0] RESOLUTION_ADDR = 3'd0;
	localparam logic [1:0] MODE_UNUSED     = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] row;
		logic [9:0] column;
		logic       last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = RESOLUTION_ADDR;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [8:0]  row;
	logic [9:0]  column;
	logic        last;

	photo_ycc_band_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.row(row),
		.column(column),
		.last(last)
	);

	// Decoder model state: line stores, stream position and the mode register.
	logic [7:0]  luma_one_mem [MAX_WIDTH];
	logic [7:0]  luma_two_mem [MAX_WIDTH];
	logic [7:0]  cb_mem [MAX_WIDTH/2];
	phase_t      row_kind = PHASE_LUMA_ONE;
	int unsigned byte_col = 0;
	int unsigned band_no = 0;
	logic [1:0]  mode_reg = MODE_192;

	pixel_t      pixel_q [$];
	pixel_t      want;
	int          mismatches = 0;
	int          pixels_checked = 0;
	int          bytes_sent = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#300_000;
		$display("Timed out with %0d pixels outstanding", pixel_q.size());
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned image_width();
		int unsigned m;
		m = (mode_reg > MODE_768) ? 2 : mode_reg;
		while (m > 0 && (192 << m) > MAX_WIDTH)
			m--;
		return 192 << m;
	endfunction

	// Negative sums go to zero; the rest are truncated and saturated at 255.
	function automatic logic [7:0] clamp_channel(input longint s);
		if (s < 0)
			return 8'd0;
		if ((s >>> 16) > 255)
			return 8'd255;
		return s[23:16];
	endfunction

	function automatic pixel_t ycc_pixel(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr, input int unsigned r, input int unsigned c, input logic fin);
		pixel_t p;
		longint luma;
		longint dcb;
		longint dcr;
		luma = COEF_Y * longint'(y);
		dcb = longint'(cb) - CB_CENTER;
		dcr = longint'(cr) - CR_CENTER;
		p.red = clamp_channel(luma + COEF_R_CR * dcr);
		p.green = clamp_channel(luma + COEF_G_CB * dcb + COEF_G_CR * dcr);
		p.blue = clamp_channel(luma + COEF_B_CB * dcb);
		p.row = r[8:0];
		p.column = c[9:0];
		p.last = fin;
		return p;
	endfunction

	// Advance the model by one accepted byte; a Cr byte queues its four pixels.
	task automatic decode_byte(input logic [7:0] b);
		int unsigned w;
		int unsigned half;
		int unsigned col;
		int unsigned k;
		int unsigned r0;
		int unsigned c0;
		logic fin;
		w = image_width();
		half = w / 2;
		col = byte_col;
		if (col >= w)
			col = w - 1;
		case (row_kind)
			PHASE_LUMA_ONE: luma_one_mem[col] = b;
			PHASE_LUMA_TWO: luma_two_mem[col] = b;
			default: begin
				if (col < half) begin
					cb_mem[col] = b;
				end else begin
					k = col - half;
					r0 = 2 * band_no;
					c0 = 2 * k;
					fin = (k == half - 1) && (band_no + 1 >= w / 3);
					pixel_q.push_back(ycc_pixel(luma_one_mem[c0], cb_mem[k], b, r0, c0, 1'b0));
					pixel_q.push_back(ycc_pixel(luma_one_mem[c0 + 1], cb_mem[k], b, r0, c0 + 1,
						1'b0));
					pixel_q.push_back(ycc_pixel(luma_two_mem[c0], cb_mem[k], b, r0 + 1, c0, 1'b0));
					pixel_q.push_back(ycc_pixel(luma_two_mem[c0 + 1], cb_mem[k], b, r0 + 1,
						c0 + 1, fin));
				end
			end
		endcase
		col++;
		if (col >= w) begin
			col = 0;
			if (row_kind == PHASE_CHROMA) begin
				row_kind = PHASE_LUMA_ONE;
				band_no++;
				if (band_no >= w / 3)
					band_no = 0;
			end else begin
				row_kind = phase_t'(row_kind + 1);
			end
		end
		byte_col = col;
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pixel_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel rgb %0d %0d %0d at row %0d column %0d",
					red, green, blue, row, column));
			end else begin
				want = pixel_q.pop_front();
				pixels_checked++;
				if ({red, green, blue, row, column, last} !== want)
					report_mismatch($sformatf(
						"expected rgb %0d %0d %0d row %0d col %0d last %0d, got %0d %0d %0d row %0d col %0d last %0d",
						want.red, want.green, want.blue, want.row, want.column, want.last,
						red, green, blue, row, column, last));
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		data_valid <= 1'b0;
	endtask

	// Mode writes only happen once the decoder has drained, then the value is read back.
	task automatic set_resolution(input logic [1:0] value);
		idle_input();
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RESOLUTION_ADDR;
		pwdata <= {30'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		mode_reg = value;
		row_kind = PHASE_LUMA_ONE;
		byte_col = 0;
		band_no = 0;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {30'd0, value})
			report_mismatch($sformatf("mode readback expected %0d, got %0h", value, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte(input int unsigned i);
		case (i % 8)
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'd156;
			3: return 8'd137;
			4: return 8'h01;
			5: return 8'hFE;
			6: return 8'h80;
			default: return 8'h7F;
		endcase
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(3) == 0)
			return pick_byte($urandom_range(7));
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_bytes(input int n);
		for (int i = 0; i < n; i++)
			send_byte(random_byte());
	endtask

	// One quarter of the Cr half. Cb byte k runs through eight values in turn and Cr byte k
	// steps every eight bytes, so the first 64 Cr bytes meet every extreme and center pair.
	task automatic send_cr_quarter(input int unsigned part);
		int unsigned quarter;
		quarter = image_width() / 8;
		for (int unsigned k = part * quarter; k < (part + 1) * quarter; k++)
			send_byte(pick_byte(k / 8));
	endtask

	// A mode write part way through luma row one, first to the unused code and then
	// back, so the band that follows only decodes right if the counters restart.
	task automatic test_restart();
		set_idling(28, 28);
		send_random_bytes(16);
		set_resolution(MODE_UNUSED);
		send_random_bytes(16);
		set_resolution(MODE_192);
	endtask

	// Both luma rows and the Cb half of one band, taken back to back.
	task automatic test_luma_and_cb();
		int unsigned w;
		w = image_width();
		set_idling(0, 0);
		for (int unsigned c = 0; c < w; c++)
			send_byte(pick_byte(c));
		for (int unsigned c = 0; c < w; c++)
			send_byte(random_byte());
		for (int unsigned k = 0; k < w / 2; k++)
			send_byte(pick_byte(k));
	endtask

	task automatic test_no_idling();
		set_idling(0, 0);
		send_cr_quarter(0);
	endtask

	task automatic test_sender_idle();
		set_idling(84, 0);
		send_cr_quarter(1);
	endtask

	task automatic test_receiver_stall();
		set_idling(0, 84);
		send_cr_quarter(2);
	endtask

	task automatic test_both_idle();
		set_idling(28, 28);
		send_cr_quarter(3);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_restart();
		test_luma_and_cb();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		idle_input();
		for (int i = 0; i < 20000 && pixel_q.size() != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d pixels from %0d bytes: a mid-row restart through the unused mode",
			pixels_checked, bytes_sent);
		$display("code, then one narrow band with every extreme Cb/Cr pair under four idling mixes.");
		if (pixel_q.size() != 0)
			$display("%0d expected pixels never arrived", pixel_q.size());
		if (mismatches == 0 && pixel_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule
